// File: hdl/midi1_event_to_ump_converter_macros.svh
// assertion macros used by the converter controller
`ifndef MIDI1_EVENT_TO_UMP_CONVERTER_MACROS_SVH
`define MIDI1_EVENT_TO_UMP_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define M1U_ASSERT_SAME(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define M1U_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

// File: hdl/m1u_pkg.sv
// shared types and constants of the midi 1.0 event to ump converter
package m1u_pkg;

  localparam int TickW     = 64;
  localparam int DeltaW    = 28;
  localparam int BpmW      = 42;
  localparam int DivisorW  = 24;
  localparam int DivBits   = BpmW;
  localparam int DivCntW   = $clog2(DivBits);
  localparam int NumKinds  = 4;

  localparam logic            OpEvent        = 1'b0;
  localparam logic            OpEnd          = 1'b1;
  localparam logic [6:0]      MetaTempo      = 7'h51;
  localparam logic [6:0]      MetaSignature  = 7'h58;
  localparam logic [7:0]      StatusMeta     = 8'hFF;
  localparam logic [7:0]      StatusSysex    = 8'hF0;
  localparam logic [7:0]      StatusSysexEnd = 8'hF7;
  localparam logic [3:0]      HiSystem       = 4'hF;
  localparam logic [3:0]      HiProgram      = 4'hC;
  localparam logic [3:0]      HiPressure     = 4'hD;
  localparam logic [3:0]      UmpTypeSystem  = 4'h1;
  localparam logic [3:0]      UmpTypeVoice   = 4'h2;
  localparam logic [3:0]      UmpGroup       = 4'h0;
  localparam logic [BpmW-1:0] DefaultBpm     = 42'd7864320;
  localparam logic [BpmW-1:0] TempoDividend  = 42'd3932160000000;
  localparam logic [7:0]      DefaultNum     = 8'd4;
  localparam logic [7:0]      DefaultDen     = 8'd4;
  localparam logic [7:0]      DefaultClocks  = 8'd24;
  localparam logic [7:0]      DefaultTsq     = 8'd8;
  localparam logic [7:0]      MaxDenExp      = 8'd7;
  localparam logic [2:0]      MinTempoLen    = 3'd3;
  localparam logic [2:0]      MinSigLen      = 3'd2;
  localparam logic [2:0]      ClocksLen      = 3'd3;
  localparam logic [2:0]      TsqLen         = 3'd4;

  typedef enum logic [1:0] {
    KIND_UMP   = 2'd0,
    KIND_TEMPO = 2'd1,
    KIND_SIG   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  // one bit per result kind, indexed by kind value
  typedef logic [NumKinds-1:0] res_mask_t;

  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  clear;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    res_mask_t mask;
    logic      need_div;
  } stat_t;

endpackage

// File: hdl/m1u_ctrl.sv
// controller: accepts items, sequences the divider and the result transactions
`include "midi1_event_to_ump_converter_macros.svh"

module m1u_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           last,
  input  m1u_pkg::stat_t stat,
  output m1u_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                         state, state_next;
  m1u_pkg::res_mask_t             pending, pending_next;
  logic [m1u_pkg::DivCntW-1:0]    cnt, cnt_next;
  m1u_pkg::kind_t                 cur_kind;
  m1u_pkg::res_mask_t             kind_bit;
  logic                           accept;
  logic                           pop;

  always_comb begin
    if (pending[m1u_pkg::KIND_UMP]) begin
      cur_kind = m1u_pkg::KIND_UMP;
    end else if (pending[m1u_pkg::KIND_TEMPO]) begin
      cur_kind = m1u_pkg::KIND_TEMPO;
    end else if (pending[m1u_pkg::KIND_SIG]) begin
      cur_kind = m1u_pkg::KIND_SIG;
    end else begin
      cur_kind = m1u_pkg::KIND_DONE;
    end
  end

  assign kind_bit  = m1u_pkg::res_mask_t'(1) << cur_kind;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign last      = $onehot(pending);
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  assign cmd.load     = accept;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.clear    = pop && (cur_kind == m1u_pkg::KIND_DONE);
  assign cmd.kind     = cur_kind;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cnt_next     = cnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pending_next = stat.mask;
          cnt_next     = m1u_pkg::DivCntW'(m1u_pkg::DivBits - 1);
          if (stat.need_div) begin
            state_next = S_DIV;
          end else if (stat.mask != '0) begin
            state_next = S_OUT;
          end
        end
      end
      S_DIV: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (pop) begin
          pending_next = pending & ~kind_bit;
          if (last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= '0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      cnt     <= cnt_next;
    end
  end

  `M1U_ASSERT_SAME(a_out_has_work, state == S_OUT, pending != '0, "result shown with nothing pending")
  `M1U_ASSERT_SAME(a_done_is_last, out_valid && cur_kind == m1u_pkg::KIND_DONE, last, "done marker not last")
  `M1U_ASSERT_NEXT(a_last_frees, out_valid && out_ready && last, state == S_IDLE, "no return to idle after last")
  `M1U_ASSERT_NEXT(a_div_ends, state == S_DIV && cnt == '0, state == S_OUT, "divider did not hand over")

endmodule

// File: hdl/m1u_datapath.sv
// datapath: tick counter, item latch, tempo divider and result field formatting
module m1u_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          capture_meta,
  input  logic                          opcode,
  input  logic [m1u_pkg::DeltaW-1:0]    delta_time,
  input  logic [7:0]                    status,
  input  logic [6:0]                    data_first,
  input  logic [6:0]                    data_second,
  input  logic [6:0]                    meta_kind,
  input  logic [2:0]                    meta_length,
  input  logic [7:0]                    meta_byte0,
  input  logic [7:0]                    meta_byte1,
  input  logic [7:0]                    meta_byte2,
  input  logic [7:0]                    meta_byte3,
  input  m1u_pkg::cmd_t                 cmd,
  output m1u_pkg::stat_t                stat,
  output logic [m1u_pkg::TickW-1:0]     tick_stamp,
  output logic [31:0]                   ump_word,
  output logic [m1u_pkg::BpmW-1:0]      tempo_bpm,
  output logic [7:0]                    sig_numerator,
  output logic [7:0]                    sig_denominator,
  output logic [7:0]                    clocks_per_click,
  output logic [7:0]                    thirty_seconds_per_quarter
);

  logic                             capture;
  logic [m1u_pkg::TickW-1:0]        tick_count;
  logic                             tempo_seen;
  logic                             signature_seen;

  logic                             op_q;
  logic [7:0]                       status_q;
  logic [6:0]                       d1_q;
  logic [6:0]                       d2_q;
  logic [2:0]                       mlen_q;
  logic [7:0]                       b0_q;
  logic [7:0]                       b1_q;
  logic [7:0]                       b2_q;
  logic [7:0]                       b3_q;

  logic [m1u_pkg::BpmW-1:0]         quo;
  logic [m1u_pkg::DivisorW-1:0]     rem;
  logic [m1u_pkg::DivisorW:0]       trial;
  logic [m1u_pkg::DivisorW:0]       diff;
  logic                             fits;
  logic [m1u_pkg::DivisorW-1:0]     divisor;

  logic                             is_meta;
  logic                             is_tempo;
  logic                             is_sig;
  logic                             is_ump;
  m1u_pkg::res_mask_t               mask;

  logic [7:0]                       den_exp;
  logic [7:0]                       low_byte;
  logic [3:0]                       ump_type;
  logic [31:0]                      word;

  // classify the offered item
  always_comb begin
    is_meta  = (status == m1u_pkg::StatusMeta);
    is_tempo = is_meta && capture && (meta_kind == m1u_pkg::MetaTempo)
               && (meta_length >= m1u_pkg::MinTempoLen);
    is_sig   = is_meta && capture && !is_tempo && (meta_kind == m1u_pkg::MetaSignature)
               && (meta_length >= m1u_pkg::MinSigLen);
    is_ump   = !is_meta && status[7] && (status != m1u_pkg::StatusSysex)
               && (status != m1u_pkg::StatusSysexEnd);
    mask = '0;
    if (opcode) begin
      mask[m1u_pkg::KIND_TEMPO] = capture && !tempo_seen;
      mask[m1u_pkg::KIND_SIG]   = capture && !signature_seen;
      mask[m1u_pkg::KIND_DONE]  = 1'b1;
    end else begin
      mask[m1u_pkg::KIND_UMP]   = is_ump;
      mask[m1u_pkg::KIND_TEMPO] = is_tempo;
      mask[m1u_pkg::KIND_SIG]   = is_sig;
    end
    stat.mask     = mask;
    stat.need_div = !opcode && is_tempo;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capture        <= 1'b1;
      tick_count     <= '0;
      tempo_seen     <= 1'b0;
      signature_seen <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capture <= capture_meta;
      end
      if (cmd.clear) begin
        tick_count     <= '0;
        tempo_seen     <= 1'b0;
        signature_seen <= 1'b0;
      end else if (cmd.load && !opcode) begin
        tick_count <= tick_count + {{(m1u_pkg::TickW - m1u_pkg::DeltaW){1'b0}}, delta_time};
        if (is_tempo) begin
          tempo_seen <= 1'b1;
        end
        if (is_sig) begin
          signature_seen <= 1'b1;
        end
      end
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= opcode;
      status_q <= status;
      d1_q     <= data_first;
      d2_q     <= data_second;
      mlen_q   <= meta_length;
      b0_q     <= meta_byte0;
      b1_q     <= meta_byte1;
      b2_q     <= meta_byte2;
      b3_q     <= meta_byte3;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign divisor = {b0_q, b1_q, b2_q};
  assign trial   = {rem, quo[m1u_pkg::BpmW-1]};
  assign diff    = trial - {1'b0, divisor};
  assign fits    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= m1u_pkg::TempoDividend;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[m1u_pkg::BpmW-2:0], fits};
      rem <= fits ? diff[m1u_pkg::DivisorW-1:0] : trial[m1u_pkg::DivisorW-1:0];
    end
  end

  // ump word
  always_comb begin
    if (status_q[7:4] == m1u_pkg::HiSystem) begin
      ump_type = m1u_pkg::UmpTypeSystem;
    end else begin
      ump_type = m1u_pkg::UmpTypeVoice;
    end
    if (status_q[7:4] == m1u_pkg::HiProgram || status_q[7:4] == m1u_pkg::HiPressure) begin
      low_byte = 8'h00;
    end else begin
      low_byte = {1'b0, d2_q};
    end
    word = {ump_type, m1u_pkg::UmpGroup, status_q, 1'b0, d1_q, low_byte};
  end

  assign den_exp = (b1_q > m1u_pkg::MaxDenExp) ? m1u_pkg::MaxDenExp : b1_q;

  // result fields
  always_comb begin
    tick_stamp                 = tick_count;
    ump_word                   = '0;
    tempo_bpm                  = '0;
    sig_numerator              = '0;
    sig_denominator            = '0;
    clocks_per_click           = '0;
    thirty_seconds_per_quarter = '0;
    case (cmd.kind)
      m1u_pkg::KIND_UMP: begin
        ump_word = word;
      end
      m1u_pkg::KIND_TEMPO: begin
        if (op_q) begin
          tick_stamp = '0;
          tempo_bpm  = m1u_pkg::DefaultBpm;
        end else if (divisor == '0) begin
          tempo_bpm = m1u_pkg::DefaultBpm;
        end else begin
          tempo_bpm = quo;
        end
      end
      m1u_pkg::KIND_SIG: begin
        if (op_q) begin
          tick_stamp                 = '0;
          sig_numerator              = m1u_pkg::DefaultNum;
          sig_denominator            = m1u_pkg::DefaultDen;
          clocks_per_click           = m1u_pkg::DefaultClocks;
          thirty_seconds_per_quarter = m1u_pkg::DefaultTsq;
        end else begin
          sig_numerator   = b0_q;
          sig_denominator = 8'd1 << den_exp[2:0];
          clocks_per_click = (mlen_q >= m1u_pkg::ClocksLen) ? b2_q : m1u_pkg::DefaultClocks;
          thirty_seconds_per_quarter = (mlen_q >= m1u_pkg::TsqLen) ? b3_q
                                                                  : m1u_pkg::DefaultTsq;
        end
      end
      default: begin
        tick_stamp = tick_count;
      end
    endcase
  end

endmodule

// File: hdl/midi1_event_to_ump_converter.sv
// top level of the midi 1.0 event to ump converter
//
// Input channel (in_valid/in_ready) takes one decoded file event or an end item
// per transaction; output channel (out_valid/out_ready) gives zero to three
// result transactions per item, the final one flagged by last. The single
// register capture_meta is written through cfg_valid/cfg_ready, always ready.
// The user must change it only while the block is idle; it is not enforced.
// One item is handled at a time: in_ready is high only while idle.
// A channel or system message is offered as a result the cycle after accept.
// A tempo event runs the restoring divider, one quotient bit per cycle, and
// its result is offered once the divider finishes. An end item gives up to
// three results, one per cycle when the receiver is ready. An item without
// results leaves the block idle, so the input stays ready.
// When the receiver stalls, the result holds and no new item is taken.
// Synchronous reset clears the tick count, the seen flags and all control
// state, and sets capture_meta to 1; the controller returns to idle.
module midi1_event_to_ump_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       capture_meta,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [m1u_pkg::DeltaW-1:0] delta_time,
  input  logic [7:0]                 status,
  input  logic [6:0]                 data_first,
  input  logic [6:0]                 data_second,
  input  logic [6:0]                 meta_kind,
  input  logic [2:0]                 meta_length,
  input  logic [7:0]                 meta_byte0,
  input  logic [7:0]                 meta_byte1,
  input  logic [7:0]                 meta_byte2,
  input  logic [7:0]                 meta_byte3,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [m1u_pkg::TickW-1:0]  tick_stamp,
  output logic [31:0]                ump_word,
  output logic [m1u_pkg::BpmW-1:0]   tempo_bpm,
  output logic [7:0]                 sig_numerator,
  output logic [7:0]                 sig_denominator,
  output logic [7:0]                 clocks_per_click,
  output logic [7:0]                 thirty_seconds_per_quarter,
  output logic                       last
);

  m1u_pkg::cmd_t  cmd;
  m1u_pkg::stat_t stat;

  assign cfg_ready = 1'b1;
  assign kind      = cmd.kind;

  m1u_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .stat      (stat),
    .cmd       (cmd)
  );

  m1u_datapath u_datapath (
    .clk                        (clk),
    .rst                        (rst),
    .cfg_valid                  (cfg_valid),
    .capture_meta               (capture_meta),
    .opcode                     (opcode),
    .delta_time                 (delta_time),
    .status                     (status),
    .data_first                 (data_first),
    .data_second                (data_second),
    .meta_kind                  (meta_kind),
    .meta_length                (meta_length),
    .meta_byte0                 (meta_byte0),
    .meta_byte1                 (meta_byte1),
    .meta_byte2                 (meta_byte2),
    .meta_byte3                 (meta_byte3),
    .cmd                        (cmd),
    .stat                       (stat),
    .tick_stamp                 (tick_stamp),
    .ump_word                   (ump_word),
    .tempo_bpm                  (tempo_bpm),
    .sig_numerator              (sig_numerator),
    .sig_denominator            (sig_denominator),
    .clocks_per_click           (clocks_per_click),
    .thirty_seconds_per_quarter (thirty_seconds_per_quarter)
  );

endmodule
